@@ design/dfr_pkg.sv @@
// Shared types and constants for the delta feature regression block.
package dfr_pkg;

    localparam int DEF_MAX_DIMS    = 16;
    localparam int DEF_MAX_WINDOW  = 3;
    localparam int DEF_JOB_DEPTH   = 4;

    localparam int SLOT_W   = 3;
    localparam int DIM_W    = 4;
    localparam int DIMS_W   = 5;
    localparam int WIN_W    = 2;
    localparam int SAMPLE_W = 16;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_DIMS   = 1'b1;

    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic [DIMS_W-1:0] dims;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] newest;
        logic [SLOT_W-1:0] oldest;
        logic [WIN_W-1:0]  frame_back;
        logic              last;
    } job_t;

    typedef enum logic {
        F_TAKE,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_DRAIN,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

@@ design/dfr_if.sv @@
// Stream channel interfaces: feature words in, delta words out.
interface dfr_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   feature_value;
    logic                 end_of_sequence;

    modport source (output valid, output feature_value, output end_of_sequence, input ready);
    modport sink   (input valid, input feature_value, input end_of_sequence, output ready);
endinterface

interface dfr_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   delta_value;
    logic [3:0]           dim_index;
    logic                 last_of_sequence;

    modport source (output valid, output delta_value, output dim_index,
                    output last_of_sequence, input ready);
    modport sink   (input valid, input delta_value, input dim_index,
                    input last_of_sequence, output ready);
endinterface

@@ design/dfr_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module dfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 112
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ design/dfr_queue.sv @@
// Short job queue between the front and the back.
module dfr_queue import dfr_pkg::*; #(
    parameter int DEPTH = DEF_JOB_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ design/dfr_front.sv @@
// Front: takes feature words, fills the frame ring, queues frame jobs.
module dfr_front import dfr_pkg::*; #(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cfg_t                                          cfg,
    dfr_in_if.sink                                        features,
    input  logic                                          back_clear,
    output logic                                          job_push,
    output job_t                                          job,
    input  logic                                          job_full,
    output logic                                          ram_wr_en,
    output logic [$clog2((2*MAX_WINDOW+1)*MAX_DIMS)-1:0] ram_wr_addr,
    output logic [SAMPLE_W-1:0]                           ram_wr_data
);

    localparam int RING   = 2 * MAX_WINDOW + 1;
    localparam int ADDR_W = $clog2(RING * MAX_DIMS);

    front_state_t      state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] cf_reg, cf_next;
    logic [DIM_W-1:0]  pos_reg, pos_next;
    logic [WIN_W-1:0]  b_reg, b_next;
    logic              eos_mode_reg, eos_mode_next;
    logic [SLOT_W-1:0] newest_reg, newest_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;

    logic              accept;
    logic              completed;
    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] cf_new;
    logic [SLOT_W-1:0] newest_new;
    logic [SLOT_W-1:0] start_raw;
    logic              job_due;
    logic              push_done;

    assign accept    = features.valid && features.ready;
    assign completed = ({1'b0, pos_reg} + 1'b1) >= cfg.dims;
    assign slot_inc  = (slot_reg == SLOT_W'(RING - 1)) ? '0 : slot_reg + 1'b1;
    assign cf_new    = (completed && (cf_reg < SLOT_W'(RING))) ? cf_reg + 1'b1 : cf_reg;
    assign newest_new = completed ? slot_reg
                      : ((slot_reg == '0) ? SLOT_W'(RING - 1) : slot_reg - 1'b1);
    assign start_raw = completed ? SLOT_W'(cfg.win) : SLOT_W'(cfg.win) - 1'b1;
    assign job_due   = features.end_of_sequence ? (cf_new != '0)
                     : (completed && ({1'b0, cf_new} >= ({2'b0, cfg.win} + 1'b1)));
    assign push_done = !job_full && (!eos_mode_reg || (b_reg == '0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_TAKE:
            begin
                if (accept && job_due)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_done)
                begin
                    state_next = F_TAKE;
                end
            end
            default: state_next = F_TAKE;
        endcase
    end

    // outputs
    always_comb
    begin
        features.ready = 1'b0;
        job_push       = 1'b0;
        case (state_reg)
            F_TAKE:  features.ready = back_clear;
            F_PUSH:  job_push = !job_full;
            default: features.ready = 1'b0;
        endcase
    end

    assign job.newest     = newest_reg;
    assign job.oldest     = oldest_reg;
    assign job.frame_back = b_reg;
    assign job.last       = eos_mode_reg && (b_reg == '0);

    assign ram_wr_en   = accept;
    assign ram_wr_addr = ADDR_W'(slot_reg) * ADDR_W'(MAX_DIMS) + ADDR_W'(pos_reg);
    assign ram_wr_data = features.feature_value;

    // frame counters and job setup
    always_comb
    begin
        slot_next     = slot_reg;
        cf_next       = cf_reg;
        pos_next      = pos_reg;
        b_next        = b_reg;
        eos_mode_next = eos_mode_reg;
        newest_next   = newest_reg;
        oldest_next   = oldest_reg;
        if (accept)
        begin
            newest_next = newest_new;
            oldest_next = cf_new - 1'b1;
            if (completed)
            begin
                pos_next  = '0;
                slot_next = slot_inc;
                cf_next   = cf_new;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (features.end_of_sequence)
            begin
                eos_mode_next = 1'b1;
                b_next = (start_raw > cf_new - 1'b1) ? WIN_W'(cf_new - 1'b1)
                                                      : WIN_W'(start_raw);
                slot_next = '0;
                cf_next   = '0;
                pos_next  = '0;
            end
            else
            begin
                eos_mode_next = 1'b0;
                b_next        = cfg.win;
            end
        end
        else if (job_push && eos_mode_reg && (b_reg != '0))
        begin
            b_next = b_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_TAKE;
            slot_reg  <= '0;
            cf_reg    <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            cf_reg    <= cf_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        eos_mode_reg <= eos_mode_next;
        newest_reg   <= newest_next;
        oldest_reg   <= oldest_next;
    end

endmodule

@@ design/dfr_back.sv @@
// Back: runs frame jobs, accumulates regression sums, divides and saturates.
module dfr_back import dfr_pkg::*; #(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cfg_t                                          cfg,
    input  job_t                                          job,
    input  logic                                          job_avail,
    output logic                                          job_pop,
    output logic                                          idle,
    output logic [$clog2((2*MAX_WINDOW+1)*MAX_DIMS)-1:0] rd_addr_a,
    output logic [$clog2((2*MAX_WINDOW+1)*MAX_DIMS)-1:0] rd_addr_b,
    input  logic [SAMPLE_W-1:0]                           rd_data_a,
    input  logic [SAMPLE_W-1:0]                           rd_data_b,
    dfr_out_if.source                                     deltas
);

    localparam int RING   = 2 * MAX_WINDOW + 1;
    localparam int ADDR_W = $clog2(RING * MAX_DIMS);
    localparam int ACC_W  = 20;
    localparam int RCP_W  = 24;
    localparam int PROD_W = ACC_W + RCP_W;

    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] newest,
                                                    input logic [SLOT_W-1:0] k);
        logic [SLOT_W:0] t;
        t = {1'b0, newest} + (SLOT_W+1)'(RING) - {1'b0, k};
        if (t >= (SLOT_W+1)'(RING))
        begin
            t = t - (SLOT_W+1)'(RING);
        end
        return t[SLOT_W-1:0];
    endfunction

    // 2 * sum n^2 and floor(2^24 / that)
    function automatic logic [4:0] den_of(input logic [WIN_W-1:0] w);
        case (w)
            2'd2:    return 5'd10;
            2'd3:    return 5'd28;
            default: return 5'd2;
        endcase
    endfunction

    function automatic logic [RCP_W-1:0] recip_of(input logic [WIN_W-1:0] w);
        case (w)
            2'd2:    return 24'd1677721;
            2'd3:    return 24'd599186;
            default: return 24'd8388608;
        endcase
    endfunction

    back_state_t              state_reg, state_next;
    job_t                     job_reg;
    logic [DIM_W-1:0]         d_reg;
    logic [WIN_W-1:0]         n_reg;
    logic                     pend_reg;
    logic [WIN_W-1:0]         pend_n_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [ACC_W-1:0]         y_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       out_delta_reg;
    logic [DIM_W-1:0]         out_dim_reg;
    logic                     out_last_reg;

    logic                     issue;
    logic                     load_out;
    logic                     out_free;
    logic                     elem_last;
    logic [WIN_W-1:0]         nb;
    logic [SLOT_W-1:0]        pb_raw;
    logic [SLOT_W-1:0]        pb;
    logic signed [ACC_W-1:0]  diff;
    logic signed [ACC_W-1:0]  term;
    logic [4:0]               den;
    logic [ACC_W-1:0]         mag;
    logic [ACC_W-1:0]         y_calc;
    logic [PROD_W-1:0]        prod_calc;
    logic [ACC_W-1:0]         qa;
    logic [ACC_W-1:0]         rem;
    logic [ACC_W-1:0]         q;
    logic signed [15:0]       delta_calc;

    assign den       = den_of(cfg.win);
    assign out_free  = !out_valid_reg || deltas.ready;
    assign elem_last = ({1'b0, d_reg} + 1'b1) == cfg.dims;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job_avail)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                if (n_reg == cfg.win)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN: state_next = B_DIV;
            B_DIV:   state_next = B_OUT;
            B_OUT:
            begin
                if (out_free)
                begin
                    state_next = elem_last ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop  = 1'b0;
        idle     = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                idle    = 1'b1;
                job_pop = job_avail;
            end
            B_READ:  issue = 1'b1;
            B_OUT:   load_out = out_free;
            default: idle = 1'b0;
        endcase
    end

    // neighbor frames, clamped at both ends
    always_comb
    begin
        nb     = (job_reg.frame_back >= n_reg) ? job_reg.frame_back - n_reg : '0;
        pb_raw = SLOT_W'(job_reg.frame_back) + SLOT_W'(n_reg);
        pb     = (pb_raw > job_reg.oldest) ? job_reg.oldest : pb_raw;
    end

    assign rd_addr_a = ADDR_W'(slot_back(job_reg.newest, SLOT_W'(nb))) * ADDR_W'(MAX_DIMS)
                     + ADDR_W'(d_reg);
    assign rd_addr_b = ADDR_W'(slot_back(job_reg.newest, pb)) * ADDR_W'(MAX_DIMS)
                     + ADDR_W'(d_reg);

    always_comb
    begin
        diff = ACC_W'($signed(rd_data_a)) - ACC_W'($signed(rd_data_b));
        term = (pend_n_reg[0] ? diff : '0) + (pend_n_reg[1] ? (diff <<< 1) : '0);
    end

    // divide by reciprocal, round half away from zero
    always_comb
    begin
        mag       = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        y_calc    = mag + ACC_W'(den >> 1);
        prod_calc = PROD_W'(y_calc) * PROD_W'(recip_of(cfg.win));
        qa        = prod_reg[PROD_W-1:RCP_W];
        rem       = y_reg - ACC_W'(qa * ACC_W'(den));
        q         = (rem >= ACC_W'(den)) ? qa + 1'b1 : qa;
        if (neg_reg)
        begin
            delta_calc = (q > ACC_W'(32768)) ? 16'sh8000 : 16'(-q);
        end
        else
        begin
            delta_calc = (q > ACC_W'(32767)) ? 16'sh7fff : 16'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (deltas.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_n_reg <= n_reg;
        if (job_pop)
        begin
            job_reg <= job;
            d_reg   <= '0;
            n_reg   <= WIN_W'(1);
            acc_reg <= '0;
        end
        if (issue)
        begin
            n_reg <= n_reg + 1'b1;
        end
        if (pend_reg)
        begin
            acc_reg <= acc_reg + term;
        end
        if (state_reg == B_DIV)
        begin
            neg_reg  <= acc_reg[ACC_W-1];
            y_reg    <= y_calc;
            prod_reg <= prod_calc;
        end
        if (load_out)
        begin
            out_delta_reg <= delta_calc;
            out_dim_reg   <= d_reg;
            out_last_reg  <= job_reg.last && elem_last;
            if (!elem_last)
            begin
                d_reg   <= d_reg + 1'b1;
                n_reg   <= WIN_W'(1);
                acc_reg <= '0;
            end
        end
    end

    assign deltas.valid            = out_valid_reg;
    assign deltas.delta_value      = out_delta_reg;
    assign deltas.dim_index        = out_dim_reg;
    assign deltas.last_of_sequence = out_last_reg;

endmodule

@@ design/delta_feature_regression.sv @@
// Top level of the delta feature regression block.
//
//  channel    dir  handshake      word
//  cfg        in   cfg_write      cfg_index (0 window, 1 dims), cfg_data[4:0]
//  features   in   valid/ready    feature_value, end_of_sequence
//  deltas     out  valid/ready    delta_value, dim_index, last_of_sequence
//
// A word that queues J frame jobs (J is 1 at a frame end, up to W+1 at end of
// sequence) holds the input while they run: per job a start step, then per
// element W ring reads over a two-port ring RAM, a drain, a divide and an
// output step. Output back-pressure stretches the output step; the input
// stays held until the back is idle and the job queue is empty.
// Reset clears control state only; ring contents are undefined until written.
// The output register lets the back start the next element while a delta waits.
module delta_feature_regression import dfr_pkg::*; #(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int JOB_DEPTH  = DEF_JOB_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [DIMS_W-1:0] cfg_data,
    dfr_in_if.sink            features,
    dfr_out_if.source         deltas
);

    localparam int RING   = 2 * MAX_WINDOW + 1;
    localparam int DEPTH  = RING * MAX_DIMS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [WIN_W-1:0]    window_reg;
    logic [DIMS_W-1:0]   dims_reg;
    cfg_t                cfg;

    logic                job_push, job_full, job_pop, job_empty;
    job_t                push_job, head_job;
    logic                back_idle;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [SAMPLE_W-1:0] ram_wr_data;
    logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
    logic [SAMPLE_W-1:0] rd_data_a, rd_data_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_W'(2);
            dims_reg   <= DIMS_W'(13);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                CFG_DIMS:   dims_reg   <= cfg_data;
                default:    dims_reg   <= dims_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.win = window_reg;
        if (window_reg == '0)
        begin
            cfg.win = WIN_W'(1);
        end
        else if (window_reg > WIN_W'(MAX_WINDOW))
        begin
            cfg.win = WIN_W'(MAX_WINDOW);
        end
        cfg.dims = dims_reg;
        if (dims_reg == '0)
        begin
            cfg.dims = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            cfg.dims = DIMS_W'(MAX_DIMS);
        end
    end

    dfr_front #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .features    (features),
        .back_clear  (back_idle && job_empty),
        .job_push    (job_push),
        .job         (push_job),
        .job_full    (job_full),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    dfr_queue #(
        .DEPTH (JOB_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (job_empty)
    );

    dfr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    dfr_back #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (head_job),
        .job_avail (!job_empty),
        .job_pop   (job_pop),
        .idle      (back_idle),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .deltas    (deltas)
    );

endmodule

@@ bench/delta_feature_regression_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for delta_feature_regression: directed script, then random utterances.
module delta_feature_regression_tb import dfr_pkg::*; ();

    localparam int SETTLE_CYCLES  = 500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 205;
    localparam int QUIET_AFTER    = 170;
    localparam int RING_SLOTS     = 7;

    localparam logic signed [15:0] MAX_POS = 16'sh7FFF;
    localparam logic signed [15:0] MAX_NEG = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] delta;
        logic [3:0]         dim;
        logic               last;
    } delta_word_t;

    localparam delta_word_t NO_DELTA = '{16'sd0, 4'd0, 1'b0};

    typedef enum {ROW_WORD, ROW_SET_WIN, ROW_SET_DIMS} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic signed [15:0] value;
        logic               eos;
        bit                 typed;
        int                 n;
        delta_word_t        r0;
        delta_word_t        r1;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write;
    logic              cfg_index;
    logic [DIMS_W-1:0] cfg_data;

    dfr_in_if  features_ch ();
    dfr_out_if deltas_ch ();

    delta_feature_regression uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .features  (features_ch),
        .deltas    (deltas_ch)
    );

    always #5 clk = ~clk;

    delta_word_t deltas_due[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          quiet       = 1'b0;

    // predictor state
    logic signed [15:0] ring_mem [RING_SLOTS][16];
    int                 fill_slot;
    int                 frames_held;
    int                 elem_pos;
    logic [1:0]         win_reg;
    logic [4:0]         dims_reg;

    function automatic int window_used();
        int w;
        w = int'(win_reg);
        if (w == 0) w = 1;
        if (w > DEF_MAX_WINDOW) w = DEF_MAX_WINDOW;
        return w;
    endfunction

    function automatic int dims_used();
        int d;
        d = int'(dims_reg);
        if (d == 0) d = 1;
        if (d > DEF_MAX_DIMS) d = DEF_MAX_DIMS;
        return d;
    endfunction

    // slot of the frame k frames before the newest complete one
    function automatic int slot_back(int k);
        int newest;
        newest = (fill_slot + RING_SLOTS - 1) % RING_SLOTS;
        return (newest + RING_SLOTS - (k % RING_SLOTS)) % RING_SLOTS;
    endfunction

    function automatic logic signed [15:0] round_sat(int num, int den);
        int q;
        int mag;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        if (num < 0) return (q > 32768) ? MAX_NEG : 16'(-q);
        return (q > 32767) ? MAX_POS : 16'(q);
    endfunction

    task automatic frame_deltas(input int back, ref delta_word_t res[$]);
        int w;
        int dims;
        int oldest;
        int den;
        int num;
        int pb;
        int nb;
        w = window_used();
        dims = dims_used();
        oldest = frames_held - 1;
        den = 0;
        for (int n = 1; n <= w; n++) den += 2 * n * n;
        for (int d = 0; d < dims; d++)
        begin
            num = 0;
            for (int n = 1; n <= w; n++)
            begin
                pb = back + n;
                nb = (back >= n) ? back - n : 0;
                if (pb > oldest) pb = oldest;
                num += n * (int'(ring_mem[slot_back(nb)][d]) - int'(ring_mem[slot_back(pb)][d]));
            end
            res.insert(res.size(), '{round_sat(num, den), 4'(d), 1'b0});
        end
    endtask

    task automatic predict_word(input logic signed [15:0] v, input logic eos,
                                ref delta_word_t res[$]);
        int  w;
        int  dims;
        int  start;
        bit  done;
        w = window_used();
        dims = dims_used();
        done = 1'b0;
        ring_mem[fill_slot][elem_pos % 16] = v;
        if (elem_pos + 1 >= dims)
        begin
            done = 1'b1;
            elem_pos = 0;
            fill_slot = (fill_slot + 1) % RING_SLOTS;
            if (frames_held < RING_SLOTS) frames_held++;
        end
        else
        begin
            elem_pos = (elem_pos + 1) % 16;
        end
        if (!eos)
        begin
            if (done && frames_held >= w + 1) frame_deltas(w, res);
        end
        else
        begin
            if (frames_held > 0)
            begin
                start = done ? w : w - 1;
                if (start > frames_held - 1) start = frames_held - 1;
                for (int b = start; b >= 0; b--) frame_deltas(b, res);
                if (res.size() > 0) res[res.size() - 1].last = 1'b1;
            end
            fill_slot = 0;
            frames_held = 0;
            elem_pos = 0;
        end
    endtask

    // drop valid, wait for all deltas, then let the back unit go quiet
    task automatic settle();
        features_ch.valid <= 1'b0;
        while (deltas_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIMS_W-1:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_WINDOW) win_reg = data[1:0];
        else dims_reg = data;
    endtask

    task automatic send_word(input logic signed [15:0] v, input logic eos);
        if (!quiet && $urandom_range(3) == 0)
        begin
            features_ch.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        features_ch.valid           <= 1'b1;
        features_ch.feature_value   <= v;
        features_ch.end_of_sequence <= eos;
        do @(posedge clk); while (!features_ch.ready);
    endtask

    task automatic send_predicted(input logic signed [15:0] v, input logic eos);
        delta_word_t got[$];
        send_word(v, eos);
        predict_word(v, eos, got);
        foreach (got[k]) deltas_due.insert(deltas_due.size(), got[k]);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0: return MAX_POS;
            1: return MAX_NEG;
            2: return 16'($urandom_range(8)) - 16'sd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random bursts of back-pressure, none near the end
    initial
    begin
        deltas_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (quiet || $urandom_range(3) != 0)
            begin
                deltas_ch.ready <= 1'b1;
            end
            else
            begin
                deltas_ch.ready <= 1'b0;
                repeat ($urandom_range(7, 1) - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        delta_word_t want;
        if (rst_n === 1'b1 && deltas_ch.valid && deltas_ch.ready)
        begin
            if (deltas_due.size() == 0)
            begin
                $error("delta word with none expected: delta_value %0d", deltas_ch.delta_value);
                fail_count++;
            end
            else
            begin
                want = deltas_due.pop_front();
                if (deltas_ch.delta_value !== want.delta)
                begin
                    $error("delta_value: expected %0d, got %0d", want.delta,
                           deltas_ch.delta_value);
                    fail_count++;
                end
                if (deltas_ch.dim_index !== want.dim)
                begin
                    $error("dim_index: expected %0d, got %0d", want.dim, deltas_ch.dim_index);
                    fail_count++;
                end
                if (deltas_ch.last_of_sequence !== want.last)
                begin
                    $error("last_of_sequence: expected %0d, got %0d", want.last,
                           deltas_ch.last_of_sequence);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((features_ch.valid && features_ch.ready) || (deltas_ch.valid && deltas_ch.ready)
            || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   script[$];
        delta_word_t got[$];
        logic [1:0]  win_pick [6];
        logic [4:0]  dims_pick [6];
        int          sent;
        int          utt;
        int          dims;
        int          frames;
        int          partial;
        int          total;

        rst_n                       <= 1'b0;
        cfg_write                   <= 1'b0;
        cfg_index                   <= CFG_WINDOW;
        cfg_data                    <= '0;
        features_ch.valid           <= 1'b0;
        features_ch.feature_value   <= '0;
        features_ch.end_of_sequence <= 1'b0;
        fill_slot   = 0;
        frames_held = 0;
        elem_pos    = 0;
        win_reg     = 2'd2;
        dims_reg    = 5'd13;
        for (int s = 0; s < RING_SLOTS; s++)
            for (int d = 0; d < 16; d++) ring_mem[s][d] = '0;

        // W=1 D=1: saturation, rounding ties, flush
        script.insert(script.size(), '{ROW_SET_WIN,  16'sd1, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_SET_DIMS, 16'sd1, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, MAX_POS, 1'b0, 1'b1, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, MAX_NEG, 1'b0, 1'b1, 1,
                                       '{MAX_NEG, 4'd0, 1'b0}, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, MAX_POS, 1'b0, 1'b1, 1, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, MAX_NEG, 1'b1, 1'b1, 2,
                                       NO_DELTA, '{MAX_NEG, 4'd0, 1'b1}});
        // end with nothing complete, then an unfinished final frame
        script.insert(script.size(), '{ROW_SET_DIMS, 16'sd2, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd100, 1'b1, 1'b1, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd5, 1'b0, 1'b1, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd7, 1'b0, 1'b1, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd9, 1'b1, 1'b1, 2,
                                       NO_DELTA, '{16'sd0, 4'd1, 1'b1}});
        // zero window and zero dims act as one
        script.insert(script.size(), '{ROW_SET_WIN,  16'sd0, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_SET_DIMS, 16'sd0, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd1000, 1'b0, 1'b1, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, -16'sd1000, 1'b1, 1'b1, 2,
                                       '{-16'sd1000, 4'd0, 1'b0}, '{-16'sd1000, 4'd0, 1'b1}});
        // dims lowered mid-frame closes the frame at once
        script.insert(script.size(), '{ROW_SET_DIMS, 16'sd4, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd11, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd22, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_SET_DIMS, 16'sd1, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd33, 1'b1, 1'b1, 1,
                                       '{16'sd0, 4'd0, 1'b1}, NO_DELTA});
        // ties round away from zero both ways
        script.insert(script.size(), '{ROW_WORD, 16'sd0, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, 16'sd1, 1'b0, 1'b1, 1,
                                       '{16'sd1, 4'd0, 1'b0}, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, -16'sd2, 1'b1, 1'b1, 2,
                                       '{-16'sd1, 4'd0, 1'b0}, '{-16'sd2, 4'd0, 1'b1}});
        // positive saturation
        script.insert(script.size(), '{ROW_WORD, MAX_NEG, 1'b0, 1'b0, 0, NO_DELTA, NO_DELTA});
        script.insert(script.size(), '{ROW_WORD, MAX_POS, 1'b1, 1'b1, 2,
                                       '{MAX_POS, 4'd0, 1'b0}, '{MAX_POS, 4'd0, 1'b1}});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_SET_WIN:  write_reg(CFG_WINDOW, script[i].value[4:0]);
                ROW_SET_DIMS: write_reg(CFG_DIMS, script[i].value[4:0]);
                default:
                begin
                    send_word(script[i].value, script[i].eos);
                    got.delete();
                    predict_word(script[i].value, script[i].eos, got);
                    if (!script[i].typed)
                    begin
                        foreach (got[k]) deltas_due.insert(deltas_due.size(), got[k]);
                    end
                    else
                    begin
                        if (script[i].n >= 1) deltas_due.insert(deltas_due.size(), script[i].r0);
                        if (script[i].n >= 2) deltas_due.insert(deltas_due.size(), script[i].r1);
                    end
                end
            endcase
        end

        // random utterances, mostly well formed; extremes of config first
        win_pick  = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
        dims_pick = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd5};
        sent = 0;
        utt  = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (utt < 6)
            begin
                write_reg(CFG_WINDOW, {3'($urandom), win_pick[utt]});
                write_reg(CFG_DIMS, dims_pick[utt]);
            end
            else if ($urandom_range(2) == 0)
            begin
                write_reg(CFG_WINDOW, 5'($urandom));
                if ($urandom_range(7) == 0) write_reg(CFG_DIMS, 5'($urandom_range(31, 12)));
                else write_reg(CFG_DIMS, 5'($urandom_range(6)));
            end
            utt++;
            dims = dims_used();
            frames = (dims >= 12) ? $urandom_range(3, 1) : $urandom_range(9, 1);
            partial = 0;
            if ($urandom_range(5) == 0)
            begin
                frames = $urandom_range(frames);
                if (dims > 1) partial = $urandom_range(dims - 1, 1);
            end
            total = frames * dims + partial;
            if (total == 0) total = 1;
            for (int k = 0; k < total; k++)
            begin
                if (sent >= QUIET_AFTER) quiet = 1'b1;
                send_predicted(pick_value(), (k == total - 1));
                sent++;
            end
        end

        settle();
        if (fail_count == 0 && deltas_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
